### sv/flt_pkg.sv
// ----------------------------------------------------------------------------
// flt_pkg
// Shared types and constants for the failure lockout table.
// ----------------------------------------------------------------------------
package flt_pkg;

   localparam int ENTRIES  = 64;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int KIND_W   = 3;
   localparam int KEY_W    = 50;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 16;
   localparam int LIMIT_W  = 16;
   localparam int STATE_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0]  RETRY_TIMEOUT_RESET = TIME_W'(3600);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BLOCK  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REPORT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 3'd5;

   // check answers
   localparam logic [STATE_W-1:0] LOCK_UNLOCKED = 2'd0;
   localparam logic [STATE_W-1:0] LOCK_LOCKED   = 2'd1;
   localparam logic [STATE_W-1:0] LOCK_ONCE     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_REG  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIM  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_TMO = 2'd2;

   typedef struct packed {
      logic                manual_lock;
      logic                auto_lock;
      logic [COUNT_W-1:0]  fail_count;
      logic [TIME_W-1:0]   lock_time;
   } entry_type;

   typedef struct packed {
      logic load_req;   // capture request word
      logic lookup;     // key match, slot select, entry read
      logic commit;     // update table, load result register
   } cmd_type;

endpackage

### sv/failure_lockout_table_unit.sv
// ----------------------------------------------------------------------------
// failure_lockout_table_unit
// Keyed lockout table for destination nodes with manual and automatic locks.
// ----------------------------------------------------------------------------
//
// channel   direction  ports                                   word
// req       in         req_valid/req_ready                     kind, key, success, time
// rsp       out        rsp_valid/rsp_ready                     lock state, found, full
// csr       in         csr_valid/csr_ready                     index, write data
//
// An accepted word passes through key lookup (all slots compared at once,
// entry memory read at the matching slot) and then execute (read-modify-write
// of the entry, result register loaded); a new word is taken only after the
// previous one has left execute. Reset clears the valid bits and sets the
// config registers to their reset values; the key CAM and entry memory are
// not cleared, every new entry is written in full when created. A result left
// untaken holds the execute step until the result register frees.
// csr writes are always taken.
// ----------------------------------------------------------------------------
module failure_lockout_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [flt_pkg::KIND_W-1:0]        req_kind,
   input  logic [flt_pkg::KEY_W-1:0]         req_node_key,
   input  logic                              req_success,
   input  logic [flt_pkg::TIME_W-1:0]        req_now_seconds,
   // response
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [flt_pkg::STATE_W-1:0]       rsp_lock_state,
   output logic                              rsp_found,
   output logic                              rsp_table_full,
   // config
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [flt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [flt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   flt_pkg::cmd_type cmd;

   // config port never back-pressures
   assign csr_ready = 1'b1;

   flt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   flt_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_kind        (req_kind),
      .req_node_key    (req_node_key),
      .req_success     (req_success),
      .req_now_seconds (req_now_seconds),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_lock_state  (rsp_lock_state),
      .rsp_found       (rsp_found),
      .rsp_table_full  (rsp_table_full)
   );

endmodule

### sv/flt_ctrl.sv
// ----------------------------------------------------------------------------
// flt_ctrl
// Sequencer: idle, lookup, execute; owns both handshakes.
// ----------------------------------------------------------------------------
module flt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output flt_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/flt_dpath.sv
// ----------------------------------------------------------------------------
// flt_dpath
// Key CAM, entry memory, update logic, config registers and result register.
// ----------------------------------------------------------------------------
module flt_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  flt_pkg::cmd_type                  cmd,
   input  logic [flt_pkg::KIND_W-1:0]        req_kind,
   input  logic [flt_pkg::KEY_W-1:0]         req_node_key,
   input  logic                              req_success,
   input  logic [flt_pkg::TIME_W-1:0]        req_now_seconds,
   input  logic                              csr_we,
   input  logic [flt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [flt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic [flt_pkg::STATE_W-1:0]       rsp_lock_state,
   output logic                              rsp_found,
   output logic                              rsp_table_full
);

   // config
   logic                           auto_reg_ff;
   logic [flt_pkg::LIMIT_W-1:0]    fail_limit_ff;
   logic [flt_pkg::TIME_W-1:0]     retry_tmo_ff;

   // request word
   logic [flt_pkg::KIND_W-1:0]     kind_ff;
   logic [flt_pkg::KEY_W-1:0]      key_ff;
   logic                           success_ff;
   logic [flt_pkg::TIME_W-1:0]     now_ff;

   // table
   logic [flt_pkg::ENTRIES-1:0]    valid_ff, valid_in;
   logic [flt_pkg::KEY_W-1:0]      cam_key_ff [flt_pkg::ENTRIES];
   flt_pkg::entry_type             mem [flt_pkg::ENTRIES];
   flt_pkg::entry_type             rd_data_ff;

   // lookup
   logic                           hit_any;
   logic [flt_pkg::IDX_W-1:0]      hit_idx;
   logic                           free_any;
   logic [flt_pkg::IDX_W-1:0]      free_idx;
   logic                           hit_ff;
   logic [flt_pkg::IDX_W-1:0]      hit_idx_ff;
   logic                           free_ok_ff;
   logic [flt_pkg::IDX_W-1:0]      free_idx_ff;

   // execute
   logic                           mem_we;
   logic [flt_pkg::IDX_W-1:0]      wr_idx;
   flt_pkg::entry_type             wr_data;
   logic                           key_we;
   logic                           valid_set;
   logic                           valid_clr;
   logic [flt_pkg::STATE_W-1:0]    lock_state;
   logic                           found;
   logic                           full;

   // result register
   logic [flt_pkg::STATE_W-1:0]    lock_state_ff;
   logic                           found_ff;
   logic                           full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_reg_ff   <= 1'b0;
         fail_limit_ff <= '0;
         retry_tmo_ff  <= flt_pkg::RETRY_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            flt_pkg::CSR_AUTO_REG:  auto_reg_ff   <= csr_wdata[0];
            flt_pkg::CSR_FAIL_LIM:  fail_limit_ff <= csr_wdata[flt_pkg::LIMIT_W-1:0];
            flt_pkg::CSR_RETRY_TMO: retry_tmo_ff  <= csr_wdata[flt_pkg::TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff    <= req_kind;
         key_ff     <= req_node_key;
         success_ff <= req_success;
         now_ff     <= req_now_seconds;
      end
   end

   // parallel compare, lowest slot wins
   always_comb begin
      hit_any  = 1'b0;
      hit_idx  = '0;
      free_any = 1'b0;
      free_idx = '0;
      for (int i = flt_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && cam_key_ff[i] == key_ff) begin
            hit_any = 1'b1;
            hit_idx = flt_pkg::IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = flt_pkg::IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff      <= hit_any;
         hit_idx_ff  <= hit_idx;
         free_ok_ff  <= free_any;
         free_idx_ff <= free_idx;
         rd_data_ff  <= mem[hit_idx];
      end
   end

   always_comb begin
      flt_pkg::entry_type        cur;
      logic                      go;
      logic [flt_pkg::COUNT_W-1:0] cnt;
      logic [flt_pkg::TIME_W-1:0]  diff;
      cur        = rd_data_ff;
      go         = 1'b0;
      cnt        = '0;
      diff       = now_ff - rd_data_ff.lock_time;
      mem_we     = 1'b0;
      wr_idx     = hit_idx_ff;
      wr_data    = rd_data_ff;
      key_we     = 1'b0;
      valid_set  = 1'b0;
      valid_clr  = 1'b0;
      lock_state = flt_pkg::LOCK_UNLOCKED;
      found      = hit_ff;
      full       = 1'b0;
      if (key_ff == '0) begin
         found = 1'b0;
         if (kind_ff == flt_pkg::KIND_CHECK) begin
            lock_state = flt_pkg::LOCK_LOCKED;
         end
      end else begin
         case (kind_ff)
            flt_pkg::KIND_INSERT: begin
               if (!hit_ff) begin
                  if (!free_ok_ff) begin
                     full = 1'b1;
                  end else begin
                     wr_idx    = free_idx_ff;
                     wr_data   = '0;
                     mem_we    = 1'b1;
                     key_we    = 1'b1;
                     valid_set = 1'b1;
                  end
               end
            end
            flt_pkg::KIND_DELETE: begin
               valid_clr = hit_ff;
            end
            flt_pkg::KIND_BLOCK: begin
               wr_data.manual_lock = 1'b1;
               mem_we              = hit_ff;
            end
            flt_pkg::KIND_CLEAR: begin
               wr_data.manual_lock = 1'b0;
               wr_data.auto_lock   = 1'b0;
               wr_data.fail_count  = '0;
               mem_we = hit_ff && (rd_data_ff.manual_lock || rd_data_ff.auto_lock);
            end
            flt_pkg::KIND_REPORT: begin
               if (hit_ff) begin
                  go = 1'b1;
               end else if (auto_reg_ff) begin
                  if (!free_ok_ff) begin
                     full = 1'b1;
                  end else begin
                     go        = 1'b1;
                     cur       = '0;
                     wr_idx    = free_idx_ff;
                     key_we    = 1'b1;
                     valid_set = 1'b1;
                  end
               end
               if (success_ff) begin
                  cur.auto_lock  = 1'b0;
                  cur.fail_count = '0;
               end else begin
                  cnt = cur.fail_count;
                  if (auto_reg_ff && cnt != flt_pkg::COUNT_MAX) begin
                     cnt = cnt + 1'b1;
                  end
                  cur.fail_count = cnt;
                  if (!cur.auto_lock && cnt >= fail_limit_ff) begin
                     cur.lock_time = now_ff;
                     cur.auto_lock = 1'b1;
                  end
               end
               wr_data = cur;
               mem_we  = go;
            end
            flt_pkg::KIND_CHECK: begin
               if (hit_ff) begin
                  if (rd_data_ff.manual_lock) begin
                     lock_state = flt_pkg::LOCK_LOCKED;
                  end else if (rd_data_ff.auto_lock) begin
                     if (diff > retry_tmo_ff) begin
                        wr_data.lock_time = now_ff;
                        mem_we            = 1'b1;
                        lock_state        = flt_pkg::LOCK_ONCE;
                     end else begin
                        lock_state = flt_pkg::LOCK_LOCKED;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && key_we) begin
         cam_key_ff[wr_idx] <= key_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && valid_set) begin
         valid_in[wr_idx] = 1'b1;
      end
      if (cmd.commit && valid_clr) begin
         valid_in[hit_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         lock_state_ff <= lock_state;
         found_ff      <= found;
         full_ff       <= full;
      end
   end

   assign rsp_lock_state = lock_state_ff;
   assign rsp_found      = found_ff;
   assign rsp_table_full = full_ff;

endmodule
